### sv/qsvge_pkg.sv
// package for the qubit state vector gate engine
// shared types, codes and sizes; no dependencies
package qsvge_pkg;

   localparam int MAX_QUBITS = 10;
   localparam int COMPONENT_BITS = 32;
   localparam int FRAC_BITS = COMPONENT_BITS - 2;
   localparam int AMP_BITS = 2 * COMPONENT_BITS;
   localparam int IDX_BITS = MAX_QUBITS;

   typedef enum logic [2:0] {
      ACT_WRITE  = 3'd0,
      ACT_READ   = 3'd1,
      ACT_MATRIX = 3'd2,
      ACT_CNOT   = 3'd3,
      ACT_SWAP   = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_RANGE   = 2'd1,
      ST_SAME    = 2'd2,
      ST_UNKNOWN = 2'd3
   } status_type;

   // classified command handed from front to back
   typedef struct packed {
      logic [2:0]          act;
      logic [1:0]          status;
      logic [IDX_BITS-1:0] idx;
      logic [IDX_BITS-1:0] mask0;
      logic [IDX_BITS-1:0] mask1;
      logic [IDX_BITS-1:0] dim_m1;
      logic [AMP_BITS-1:0] value;
      logic [AMP_BITS-1:0] m00;
      logic [AMP_BITS-1:0] m01;
      logic [AMP_BITS-1:0] m10;
      logic [AMP_BITS-1:0] m11;
   } cmd_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_READ,
      BK_RDWAIT,
      BK_MUL,
      BK_SUM,
      BK_WRITE,
      BK_RESULT
   } back_state_type;

endpackage

### sv/qubit_state_vector_gate_engine.sv
// top level of the qubit state vector gate engine
// depends on qsvge_pkg, qsvge_front, qsvge_back
//
// Input channel: push/full. An item transfers when req_push is high and
// req_full low. The front classifies it into a two-entry command queue.
// Result channel: empty/pop. One result per item, the oldest on rsp_status
// and rsp_read_value while rsp_empty is low; it transfers on rsp_pop.
// Config: csr_valid/csr_ready sets qubits_in_use (n); write only when idle.
// Write and error items go straight to the result state, reads through
// read and rdwait. Gates sweep amplitude pairs through the single store
// port set: matrix 2^(n-1) pairs via read, rdwait, mul, sum, write; cnot
// and swap 2^(n-2) pairs via read, rdwait, write.
// Reset clears control state and sets n to 10; the store is undefined
// until written. A stalled receiver holds its result; the back end waits
// and the command queue fills, then req_full rises.
module qubit_state_vector_gate_engine import qsvge_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [2:0]  req_action,
   input  logic [3:0]  req_first_qubit,
   input  logic [3:0]  req_second_qubit,
   input  logic [9:0]  req_amp_index,
   input  logic [63:0] req_amp_value,
   input  logic [63:0] req_m00,
   input  logic [63:0] req_m01,
   input  logic [63:0] req_m10,
   input  logic [63:0] req_m11,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_status,
   output logic [63:0] rsp_read_value,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_qubits_in_use
);
   logic [3:0] nq_ff;
   logic [3:0] n_eff;
   logic       cmd_valid, cmd_take;
   cmd_type    cmd;

   assign csr_ready = 1'b1;

   // qubit count register
   always_ff @(posedge clock) begin
      if (reset) nq_ff <= 4'd10;
      else if (csr_valid) nq_ff <= csr_qubits_in_use;
   end

   assign n_eff = (nq_ff == 4'd0) ? 4'd1 :
                  (nq_ff > 4'(MAX_QUBITS)) ? 4'(MAX_QUBITS) : nq_ff;

   qsvge_front u_front (
      .clock, .reset, .req_push, .req_full, .req_action, .req_first_qubit,
      .req_second_qubit, .req_amp_index, .req_amp_value, .req_m00, .req_m01,
      .req_m10, .req_m11, .n_eff, .cmd_valid, .cmd_take, .cmd
   );

   qsvge_back u_back (
      .clock, .reset, .cmd_valid, .cmd_take, .cmd, .rsp_empty, .rsp_pop,
      .rsp_status, .rsp_read_value
   );
endmodule

### sv/qsvge_front.sv
// front end: accepts items, checks qubits and builds the command
// depends on qsvge_pkg
module qsvge_front import qsvge_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic [2:0]          req_action,
   input  logic [3:0]          req_first_qubit,
   input  logic [3:0]          req_second_qubit,
   input  logic [9:0]          req_amp_index,
   input  logic [63:0]         req_amp_value,
   input  logic [63:0]         req_m00,
   input  logic [63:0]         req_m01,
   input  logic [63:0]         req_m10,
   input  logic [63:0]         req_m11,
   input  logic [3:0]          n_eff,
   output logic                cmd_valid,
   input  logic                cmd_take,
   output cmd_type             cmd
);
   // two-entry command queue
   cmd_type     q_ff [2];
   logic [1:0]  cnt_ff, cnt_in;
   logic        rp_ff, rp_in, wp_ff, wp_in;
   cmd_type     c;
   logic        push_ok;
   logic [3:0]  sh0, sh1;

   assign req_full = cnt_ff[1];
   assign push_ok = req_push && !req_full;

   // classify
   always_comb begin
      c = '0;
      c.act = req_action;
      c.dim_m1 = IDX_BITS'((32'd1 << n_eff) - 32'd1);
      c.idx = req_amp_index & c.dim_m1;
      sh0 = n_eff - 4'd1 - req_first_qubit;
      sh1 = n_eff - 4'd1 - req_second_qubit;
      c.mask0 = IDX_BITS'(32'd1 << sh0);
      c.mask1 = IDX_BITS'(32'd1 << sh1);
      c.value = req_amp_value;
      c.m00 = req_m00;
      c.m01 = req_m01;
      c.m10 = req_m10;
      c.m11 = req_m11;
      c.status = ST_OK;
      unique case (req_action)
         ACT_WRITE, ACT_READ: c.status = ST_OK;
         ACT_MATRIX: if (req_first_qubit >= n_eff) c.status = ST_RANGE;
         ACT_CNOT, ACT_SWAP: begin
            if (req_first_qubit >= n_eff || req_second_qubit >= n_eff)
               c.status = ST_RANGE;
            else if (req_first_qubit == req_second_qubit)
               c.status = ST_SAME;
         end
         default: c.status = ST_UNKNOWN;
      endcase
   end

   always_comb begin
      rp_in = rp_ff ^ cmd_take;
      wp_in = wp_ff ^ push_ok;
      cnt_in = cnt_ff + {1'b0, push_ok} - {1'b0, cmd_take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rp_ff <= 1'b0;
         wp_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rp_ff <= rp_in;
         wp_ff <= wp_in;
      end
      if (push_ok) q_ff[wp_ff] <= c;
   end

   assign cmd_valid = cnt_ff != 2'd0;
   assign cmd = q_ff[rp_ff];

   // queue never overflows
   a_no_over: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("command queue overflow");
   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      cmd_take |-> cmd_valid) else $error("take from empty queue");
   a_full: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2 && !cmd_take) |=> req_full) else $error("full lost");
endmodule

### sv/qsvge_back.sv
// back end: sweeps the amplitude store and forms results
// depends on qsvge_pkg
module qsvge_back import qsvge_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         cmd_valid,
   output logic         cmd_take,
   input  cmd_type      cmd,
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output logic [1:0]   rsp_status,
   output logic [63:0]  rsp_read_value
);
   localparam int CB = COMPONENT_BITS;
   localparam int PB = 2 * CB;

   logic [AMP_BITS-1:0] mem [1 << IDX_BITS];
   back_state_type st_ff, st_in;
   cmd_type c_ff;
   logic [IDX_BITS-1:0] i_ff, i_in;
   logic [IDX_BITS-1:0] a_addr, b_addr;
   logic [AMP_BITS-1:0] ra_ff, rb_ff;
   logic [AMP_BITS-1:0] a0_ff, a1_ff;
   logic signed [PB-1:0] p_ff [16];
   logic [AMP_BITS-1:0] o0_ff, o1_ff, o0_in, o1_in;
   logic                res_v_ff;
   logic [1:0]          res_s_ff;
   logic [AMP_BITS-1:0] res_d_ff;
   logic                 done_sweep;
   logic [IDX_BITS-1:0] skip;

   // pair addresses: expand counter around cleared bits
   always_comb begin
      skip = (c_ff.act == ACT_MATRIX) ? c_ff.mask0 : (c_ff.mask0 | c_ff.mask1);
      a_addr = i_ff & ~skip;
      if (c_ff.act == ACT_MATRIX) begin
         b_addr = a_addr | c_ff.mask0;
      end else if (c_ff.act == ACT_CNOT) begin
         b_addr = a_addr | c_ff.mask0 | c_ff.mask1;
         a_addr = a_addr | c_ff.mask0;
      end else begin
         b_addr = a_addr | c_ff.mask0;
         a_addr = a_addr | c_ff.mask1;
      end
      done_sweep = (i_ff | skip) == c_ff.dim_m1;
   end

   function automatic logic signed [CB-1:0] re(input logic [AMP_BITS-1:0] p);
      re = p[2*CB-1:CB];
   endfunction
   function automatic logic signed [CB-1:0] im(input logic [AMP_BITS-1:0] p);
      im = p[CB-1:0];
   endfunction
   // round to F fraction bits, ties up
   function automatic logic signed [CB+2:0] rnd(input logic signed [PB-1:0] v);
      logic signed [PB:0] t;
      t = {v[PB-1], v} + (PB+1)'(1 << (FRAC_BITS-1));
      rnd = (CB+3)'(t >>> FRAC_BITS);
   endfunction
   function automatic logic [CB-1:0] sat(input logic signed [CB+4:0] v);
      logic signed [CB+4:0] hi, lo;
      hi = (CB+5)'((64'sd1 <<< (CB-1)) - 1);
      lo = -(CB+5)'(64'sd1 <<< (CB-1));
      if (v > hi) sat = hi[CB-1:0];
      else if (v < lo) sat = lo[CB-1:0];
      else sat = v[CB-1:0];
   endfunction

   logic signed [CB+4:0] s [4];
   always_comb begin
      s[0] = rnd(p_ff[0]) - rnd(p_ff[1]) + rnd(p_ff[2]) - rnd(p_ff[3]);
      s[1] = rnd(p_ff[4]) + rnd(p_ff[5]) + rnd(p_ff[6]) + rnd(p_ff[7]);
      s[2] = rnd(p_ff[8]) - rnd(p_ff[9]) + rnd(p_ff[10]) - rnd(p_ff[11]);
      s[3] = rnd(p_ff[12]) + rnd(p_ff[13]) + rnd(p_ff[14]) + rnd(p_ff[15]);
      o0_in = {sat(s[0]), sat(s[1])};
      o1_in = {sat(s[2]), sat(s[3])};
   end

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         BK_IDLE: if (cmd_valid && !res_v_ff) begin
            if (cmd.status != ST_OK || cmd.act == ACT_WRITE) st_in = BK_RESULT;
            else st_in = BK_READ;
         end
         BK_READ:   st_in = BK_RDWAIT;
         BK_RDWAIT: st_in = (c_ff.act == ACT_READ) ? BK_RESULT :
                            (c_ff.act == ACT_MATRIX) ? BK_MUL : BK_WRITE;
         BK_MUL:    st_in = BK_SUM;
         BK_SUM:    st_in = BK_WRITE;
         BK_WRITE:  st_in = done_sweep ? BK_RESULT : BK_READ;
         BK_RESULT: st_in = BK_IDLE;
         default:   st_in = BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd_take = (st_ff == BK_IDLE) && cmd_valid && !res_v_ff;
      i_in = i_ff;
      if (st_ff == BK_IDLE) i_in = '0;
      else if (st_ff == BK_WRITE) i_in = (i_ff | skip) + IDX_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= BK_IDLE;
         res_v_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (st_ff == BK_RESULT) res_v_ff <= 1'b1;
         else if (rsp_pop) res_v_ff <= 1'b0;
      end
      i_ff <= i_in;
      if (cmd_take) c_ff <= cmd;
      // memory port
      if (st_ff == BK_READ) begin
         ra_ff <= mem[(c_ff.act == ACT_READ) ? c_ff.idx : a_addr];
         rb_ff <= mem[b_addr];
      end
      if (st_ff == BK_RDWAIT) begin
         a0_ff <= ra_ff;
         a1_ff <= rb_ff;
      end
      if (st_ff == BK_MUL) begin
         p_ff[0]  <= re(c_ff.m00) * re(a0_ff);
         p_ff[1]  <= im(c_ff.m00) * im(a0_ff);
         p_ff[2]  <= re(c_ff.m01) * re(a1_ff);
         p_ff[3]  <= im(c_ff.m01) * im(a1_ff);
         p_ff[4]  <= re(c_ff.m00) * im(a0_ff);
         p_ff[5]  <= im(c_ff.m00) * re(a0_ff);
         p_ff[6]  <= re(c_ff.m01) * im(a1_ff);
         p_ff[7]  <= im(c_ff.m01) * re(a1_ff);
         p_ff[8]  <= re(c_ff.m10) * re(a0_ff);
         p_ff[9]  <= im(c_ff.m10) * im(a0_ff);
         p_ff[10] <= re(c_ff.m11) * re(a1_ff);
         p_ff[11] <= im(c_ff.m11) * im(a1_ff);
         p_ff[12] <= re(c_ff.m10) * im(a0_ff);
         p_ff[13] <= im(c_ff.m10) * re(a0_ff);
         p_ff[14] <= re(c_ff.m11) * im(a1_ff);
         p_ff[15] <= im(c_ff.m11) * re(a1_ff);
      end
      if (st_ff == BK_SUM) begin
         o0_ff <= o0_in;
         o1_ff <= o1_in;
      end
      if (st_ff == BK_WRITE) begin
         if (c_ff.act == ACT_MATRIX) begin
            mem[a_addr] <= o0_ff;
            mem[b_addr] <= o1_ff;
         end else begin
            mem[a_addr] <= a1_ff;
            mem[b_addr] <= a0_ff;
         end
      end
      if (st_ff == BK_RESULT && c_ff.act == ACT_WRITE && c_ff.status == ST_OK)
         mem[c_ff.idx] <= c_ff.value;
      if (st_ff == BK_RESULT) begin
         res_s_ff <= c_ff.status;
         res_d_ff <= (c_ff.act == ACT_READ && c_ff.status == ST_OK) ? a0_ff : '0;
      end
   end

   assign rsp_empty = !res_v_ff;
   assign rsp_status = res_s_ff;
   assign rsp_read_value = res_d_ff;

   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_take |-> st_ff == BK_IDLE) else $error("take while busy");
   a_res_hold: assert property (@(posedge clock) disable iff (reset)
      (res_v_ff && !rsp_pop) |=> res_v_ff) else $error("result dropped");
   a_no_take_full: assert property (@(posedge clock) disable iff (reset)
      res_v_ff |-> !cmd_take) else $error("start with result pending");
endmodule

### test/qsvge_checker.sv
// checker for the qubit state vector gate engine: predicts each result and compares
// watches the request, response and csr channels; depends on qsvge_pkg
`timescale 1ns / 1ps

module qsvge_checker import qsvge_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic [2:0]  req_action,
   input  logic [3:0]  req_first_qubit,
   input  logic [3:0]  req_second_qubit,
   input  logic [9:0]  req_amp_index,
   input  logic [63:0] req_amp_value,
   input  logic [63:0] req_m00,
   input  logic [63:0] req_m01,
   input  logic [63:0] req_m10,
   input  logic [63:0] req_m11,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic [1:0]  rsp_status,
   input  logic [63:0] rsp_read_value,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [3:0]  csr_qubits_in_use,
   output int          errors,
   output int          pending
);

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] value;
   } outcome_type;

   logic [63:0] amp_shadow [1024];
   logic [3:0]  qubit_count;
   outcome_type outcome_q [$];

   // rounded Q2.30 product, ties toward plus infinity
   function automatic longint qmul(logic [31:0] x, logic [31:0] y);
      longint p;
      p = longint'($signed(x)) * longint'($signed(y));
      return (p + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
   endfunction

   function automatic logic [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'h7fff_ffff;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   // packed complex ma*a + mb*b
   function automatic logic [63:0] cmac(logic [63:0] ma, logic [63:0] a,
                                        logic [63:0] mb, logic [63:0] b);
      longint re, im;
      re = qmul(ma[63:32], a[63:32]) - qmul(ma[31:0], a[31:0])
         + qmul(mb[63:32], b[63:32]) - qmul(mb[31:0], b[31:0]);
      im = qmul(ma[63:32], a[31:0]) + qmul(ma[31:0], a[63:32])
         + qmul(mb[63:32], b[31:0]) + qmul(mb[31:0], b[63:32]);
      return {clamp32(re), clamp32(im)};
   endfunction

   // updates the shadow vector and returns the expected response
   function automatic outcome_type apply_item();
      outcome_type o;
      int          n, dim, b0, b1;
      logic [63:0] a0, a1;
      n = (qubit_count < 1) ? 1 : (qubit_count > MAX_QUBITS) ? MAX_QUBITS : qubit_count;
      dim = 1 << n;
      o = '{ST_OK, 64'd0};
      case (req_action)
         ACT_WRITE: begin
            amp_shadow[req_amp_index & (dim - 1)] = req_amp_value;
         end
         ACT_READ: begin
            o.value = amp_shadow[req_amp_index & (dim - 1)];
         end
         ACT_MATRIX: begin
            if (req_first_qubit >= n) begin
               o.status = ST_RANGE;
            end else begin
               b0 = 1 << (n - 1 - req_first_qubit);
               for (int i = 0; i < dim; i++) begin
                  if ((i & b0) == 0) begin
                     a0 = amp_shadow[i];
                     a1 = amp_shadow[i | b0];
                     amp_shadow[i] = cmac(req_m00, a0, req_m01, a1);
                     amp_shadow[i | b0] = cmac(req_m10, a0, req_m11, a1);
                  end
               end
            end
         end
         ACT_CNOT, ACT_SWAP: begin
            if (req_first_qubit >= n || req_second_qubit >= n) begin
               o.status = ST_RANGE;
            end else if (req_first_qubit == req_second_qubit) begin
               o.status = ST_SAME;
            end else begin
               b0 = 1 << (n - 1 - req_first_qubit);
               b1 = 1 << (n - 1 - req_second_qubit);
               for (int i = 0; i < dim; i++) begin
                  if ((i & (b0 | b1)) == 0) begin
                     if (req_action == ACT_CNOT) begin
                        a0 = amp_shadow[i | b0];
                        amp_shadow[i | b0] = amp_shadow[i | b0 | b1];
                        amp_shadow[i | b0 | b1] = a0;
                     end else begin
                        a0 = amp_shadow[i | b1];
                        amp_shadow[i | b1] = amp_shadow[i | b0];
                        amp_shadow[i | b0] = a0;
                     end
                  end
               end
            end
         end
         default: begin
            o.status = ST_UNKNOWN;
         end
      endcase
      return o;
   endfunction

   assign pending = outcome_q.size();

   // compare response transfers, then predict request transfers
   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         qubit_count = 4'd10;
         outcome_q.delete();
         errors = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (outcome_q.size() == 0) begin
               $error("response transfer with nothing expected");
               errors++;
            end else begin
               want = outcome_q.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  errors++;
               end
               if (rsp_read_value !== want.value) begin
                  $error("read_value: expected %h, actual %h", want.value, rsp_read_value);
                  errors++;
               end
            end
         end
         if (csr_valid && csr_ready) qubit_count = csr_qubits_in_use;
         if (req_push && !req_full) outcome_q = {outcome_q, apply_item()};
      end
   end

   final begin
      if (outcome_q.size() != 0) $error("%0d responses never arrived", outcome_q.size());
   end

endmodule

### test/tb_top.sv
// testbench top for the qubit state vector gate engine: stimulus and verdict
// depends on qsvge_pkg, qubit_state_vector_gate_engine and qsvge_checker
`timescale 1ns / 1ps

module tb_top;
   import qsvge_pkg::*;

   localparam int CYCLE_LIMIT = 1500000;

   logic        clock = 0, reset = 1;
   logic        req_push = 0, req_full;
   logic [2:0]  req_action = 0;
   logic [3:0]  req_first_qubit = 0, req_second_qubit = 0;
   logic [9:0]  req_amp_index = 0;
   logic [63:0] req_amp_value = 0, req_m00 = 0, req_m01 = 0, req_m10 = 0, req_m11 = 0;
   logic        rsp_empty, rsp_pop = 0;
   logic [1:0]  rsp_status;
   logic [63:0] rsp_read_value;
   logic        csr_valid = 0, csr_ready;
   logic [3:0]  csr_qubits_in_use = 0;
   int          errors, pending, cycles = 0;
   int          send_idle_pct = 0, pop_stall_pct = 0, live_qubits = 10;

   qubit_state_vector_gate_engine dut (.*);
   qsvge_checker u_checker (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   // response side stalls at random
   always @(negedge clock) rsp_pop = ($urandom_range(99) >= pop_stall_pct);

   // one Q2.30 component: mostly within +-1, sometimes any pattern
   function automatic logic [31:0] rand_comp();
      if ($urandom_range(3) == 0) return $urandom;
      return $urandom_range(32'h8000_0000) - 32'h4000_0000;
   endfunction

   function automatic logic [63:0] rand_cplx();
      return {rand_comp(), rand_comp()};
   endfunction

   // one request transfer; entered and left at a falling edge
   task automatic send_item(logic [2:0] act, logic [3:0] q0, logic [3:0] q1, logic [9:0] idx,
                            logic [63:0] val, logic [63:0] a, logic [63:0] b,
                            logic [63:0] c, logic [63:0] d);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push = 0;
         @(negedge clock);
      end
      req_push = 1;
      req_action = act;
      req_first_qubit = q0;
      req_second_qubit = q1;
      req_amp_index = idx;
      req_amp_value = val;
      {req_m00, req_m01, req_m10, req_m11} = {a, b, c, d};
      @(posedge clock);
      while (req_full) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_simple(logic [2:0] act, logic [3:0] q0, logic [3:0] q1,
                              logic [9:0] idx, logic [63:0] val);
      send_item(act, q0, q1, idx, val, rand_cplx(), rand_cplx(), rand_cplx(), rand_cplx());
   endtask

   // register write once all responses are back
   task automatic set_qubits(logic [3:0] v);
      req_push = 0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_valid = 1;
      csr_qubits_in_use = v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 0;
      live_qubits = (v < 1) ? 1 : (v > MAX_QUBITS) ? MAX_QUBITS : v;
   endtask

   function automatic logic [3:0] pick_qubit();
      if ($urandom_range(9) == 0) return $urandom_range(15);
      return $urandom_range(live_qubits - 1);
   endfunction

   // mix of transfers; gates kept rare on large vectors
   task automatic random_item();
      int          roll, gate_pct;
      logic [3:0]  q0, q1;
      gate_pct = (live_qubits >= 8) ? 3 : 30;
      roll = $urandom_range(99);
      q0 = pick_qubit();
      q1 = ($urandom_range(7) == 0) ? q0 : pick_qubit();
      if (roll < gate_pct) begin
         send_item(3'($urandom_range(ACT_MATRIX, ACT_SWAP)), q0, q1, $urandom, rand_cplx(),
                   rand_cplx(), rand_cplx(), rand_cplx(), rand_cplx());
      end else if (roll < gate_pct + 4) begin
         send_simple(3'($urandom_range(ACT_SWAP + 1, 7)), q0, q1, $urandom, rand_cplx());
      end else if (roll < 60) begin
         send_simple(ACT_WRITE, q0, q1, $urandom, rand_cplx());
      end else begin
         send_simple(ACT_READ, q0, q1, $urandom, rand_cplx());
      end
   endtask

   initial begin
      logic [3:0]  phase_qubits [8];
      logic [63:0] one, big, neg;
      phase_qubits = '{4'd1, 4'd0, 4'd3, 4'd15, 4'd5, 4'd10, 4'd7, 4'd2};
      one = {32'h4000_0000, 32'h0};
      big = {32'h7fff_ffff, 32'h7fff_ffff};
      neg = {32'h8000_0000, 32'h8000_0000};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // load every amplitude so nothing unwritten is ever read
      for (int i = 0; i < 1024; i++) send_simple(ACT_WRITE, 0, 0, i, rand_cplx());

      // directed: extremes, each action, each error
      send_simple(ACT_WRITE, 0, 0, 10'd0, big);
      send_simple(ACT_WRITE, 0, 0, 10'd1023, neg);
      send_simple(ACT_WRITE, 0, 0, 10'd512, 64'd0);
      send_simple(ACT_READ, 0, 0, 10'd0, 0);
      send_simple(ACT_READ, 0, 0, 10'd1023, 0);
      send_simple(ACT_READ, 0, 0, 10'd512, 0);
      send_item(ACT_MATRIX, 4'd0, 4'd15, 0, 0, one, 64'd0, 64'd0, one);
      send_item(ACT_MATRIX, 4'd9, 4'd0, 0, 0, big, big, neg, neg);
      send_item(ACT_MATRIX, 4'd10, 4'd0, 0, 0, one, one, one, one);
      send_item(ACT_MATRIX, 4'd15, 4'd15, 0, 0, one, one, one, one);
      send_simple(ACT_CNOT, 4'd0, 4'd9, 0, 0);
      send_simple(ACT_CNOT, 4'd3, 4'd12, 0, 0);
      send_simple(ACT_CNOT, 4'd4, 4'd4, 0, 0);
      send_simple(ACT_SWAP, 4'd9, 4'd2, 0, 0);
      send_simple(ACT_SWAP, 4'd15, 4'd15, 0, 0);
      send_simple(ACT_SWAP, 4'd6, 4'd6, 0, 0);
      for (int k = ACT_SWAP + 1; k <= 7; k++) send_simple(3'(k), 0, 0, 0, 0);
      send_simple(ACT_READ, 0, 0, 10'd0, 0);
      send_simple(ACT_READ, 0, 0, 10'd1023, 0);

      // random phases over qubit counts and idle patterns
      for (int p = 0; p < 8; p++) begin
         set_qubits(phase_qubits[p]);
         case (p % 4)
            0: {send_idle_pct, pop_stall_pct} = {32'd0, 32'd0};
            1: {send_idle_pct, pop_stall_pct} = {32'd75, 32'd0};
            2: {send_idle_pct, pop_stall_pct} = {32'd0, 32'd75};
            default: {send_idle_pct, pop_stall_pct} = {32'd9, 32'd9};
         endcase
         for (int i = 0; i < 50; i++) random_item();
      end
      req_push = 0;

      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (errors == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
